>>> rtl/qcga_pkg.sv
package qcga_pkg;

	localparam int QUANT_BITS = 8;
	localparam int DATA_WIDTH = 32;
	localparam int STEP       = (1 << QUANT_BITS) - 1;
	localparam int P_W        = 33 + QUANT_BITS;
	localparam int A_W        = P_W - 1;
	localparam int DEN_W      = 32 + QUANT_BITS;
	localparam int NUM_W      = 64;
	localparam int CNT_W      = 6;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_CLIP_UPPER = 2'd0,
		CFG_CLIP_LOWER = 2'd1,
		CFG_ORIG_UPPER = 2'd2,
		CFG_ORIG_LOWER = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		REG_INSIDE,
		REG_ABOVE,
		REG_BELOW
	} region_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_RES,
		ST_DIV2,
		ST_MUL,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic signed [31:0] activation;
		logic signed [31:0] upstream_grad;
		logic               last;
	} act_t;

	typedef struct packed {
		logic signed [63:0] grad_upper;
		logic signed [63:0] grad_lower;
		logic               range_error;
	} res_t;

	typedef struct packed {
		region_t            region;
		logic [A_W-1:0]     mag;
		logic               neg;
		logic [31:0]        range;
		logic               ok;
		logic signed [31:0] grad;
		logic               last;
	} item_t;

endpackage

>>> rtl/quant_clip_gradient_accumulator_core.sv
// Accumulates the gradients of the two clip bounds of a quantizer over a
// stream of activation and gradient pairs.
// The input channel (act_valid, act_stall, act) carries one element per
// transfer; the element flagged last closes the tensor.
// The result channel (res_valid, res_stall, res) carries one transfer per
// tensor with both saturated sums and the range error flag.
// The configuration port writes the four clip registers; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Each element passes through the back end in order: a load step, serial
// remainder division, a residue step, serial quotient division, a multiply
// step and an accumulate step; the serial divider sets the pace.
// The result is registered and appears in the cycle after the last element is accumulated.
// A two-entry queue lets the front accept elements while the back end works.
// Reset clears the sums, the flag, the queue and restores register defaults.
// While the receiver stalls, the result holds and a further last element
// waits in the accumulate step.
module quant_clip_gradient_accumulator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           act_valid,
	output logic           act_stall,
	input  qcga_pkg::act_t act,
	output logic           res_valid,
	input  logic           res_stall,
	output qcga_pkg::res_t res,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import qcga_pkg::*;

	logic signed [31:0] clip_upper_q, clip_lower_q, orig_upper_q, orig_lower_q;
	item_t              front_item, queue_item;
	logic               full, empty, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_upper_q <= 32'sd65536;
			clip_lower_q <= -32'sd65536;
			orig_upper_q <= 32'sd65536;
			orig_lower_q <= -32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CLIP_UPPER: clip_upper_q <= cfg_data;
				CFG_CLIP_LOWER: clip_lower_q <= cfg_data;
				CFG_ORIG_UPPER: orig_upper_q <= cfg_data;
				CFG_ORIG_LOWER: orig_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign act_stall = full;

	qcga_front u_front (
		.act        (act),
		.clip_upper (clip_upper_q),
		.clip_lower (clip_lower_q),
		.orig_upper (orig_upper_q),
		.orig_lower (orig_lower_q),
		.item       (front_item)
	);

	qcga_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (act_valid),
		.push_data (front_item),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (queue_item)
	);

	qcga_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!empty),
		.item       (queue_item),
		.item_pop   (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);
endmodule

>>> rtl/qcga_front.sv
module qcga_front (
	input  qcga_pkg::act_t      act,
	input  logic signed [31:0]  clip_upper,
	input  logic signed [31:0]  clip_lower,
	input  logic signed [31:0]  orig_upper,
	input  logic signed [31:0]  orig_lower,
	output qcga_pkg::item_t     item
);
	import qcga_pkg::*;

	logic signed [DATA_WIDTH-1:0] x_raw;
	logic signed [DATA_WIDTH-1:0] g_raw;
	logic signed [31:0]           x;
	logic signed [31:0]           v;
	logic signed [P_W-1:0]        n;
	logic signed [32:0]           dd;
	logic signed [P_W-1:0]        n_abs;

	always_comb begin
		x_raw = act.activation[DATA_WIDTH-1:0];
		g_raw = act.upstream_grad[DATA_WIDTH-1:0];
		x = 32'(x_raw);
		if (x > clip_upper) begin
			item.region = REG_ABOVE;
		end else if (x < clip_lower) begin
			item.region = REG_BELOW;
		end else begin
			item.region = REG_INSIDE;
		end
		v = (item.region == REG_INSIDE) ? x : orig_lower;
		n = P_W'(v) * P_W'(STEP);
		n_abs = n[P_W-1] ? -n : n;
		item.mag = n_abs[A_W-1:0];
		item.neg = n[P_W-1];
		dd = 33'(orig_upper) - 33'(orig_lower);
		item.ok = !dd[32] && (dd != 33'sd0);
		item.range = dd[31:0];
		item.grad = 32'(g_raw);
		item.last = act.last;
	end
endmodule

>>> rtl/qcga_fifo.sv
module qcga_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qcga_pkg::item_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output qcga_pkg::item_t pop_data
);
	import qcga_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
		end
	end
endmodule

>>> rtl/qcga_back.sv
module qcga_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  qcga_pkg::item_t item,
	output logic            item_pop,
	output logic            res_valid,
	input  logic            res_stall,
	output qcga_pkg::res_t  res
);
	import qcga_pkg::*;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [65:0] s;
		s = 66'(a) + 66'(b);
		if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		end else if (s < -66'sh0_8000_0000_0000_0000) begin
			return -64'sh8000_0000_0000_0000;
		end
		return s[63:0];
	endfunction

	state_t             state_q, state_d;
	item_t              item_q;
	logic [DEN_W-1:0]   den_q;
	logic [31:0]        rem1_q;
	logic [DEN_W-1:0]   rem2_q;
	logic [NUM_W-1:0]   num_q;
	logic [31:0]        quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rneg_q;
	logic signed [64:0] prod_q;
	logic signed [63:0] sum_upper_q;
	logic signed [63:0] sum_lower_q;
	logic               err_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [32:0]        trial1;
	logic [DEN_W:0]     trial2;
	logic [31:0]        mag;
	logic               sgn;
	logic signed [32:0] r;
	logic [64:0]        p_abs;
	logic [63:0]        t_mag;
	logic signed [63:0] term;
	logic signed [63:0] g32;
	logic signed [63:0] next_upper;
	logic signed [63:0] next_lower;
	logic               acc_go;

	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		trial1 = {rem1_q, num_q[NUM_W-1]};
		trial2 = {rem2_q, num_q[NUM_W-1]};
		if (rem1_q == '0) begin
			mag = '0;
			sgn = 1'b0;
		end else if ({rem1_q, 1'b0} >= {1'b0, item_q.range}) begin
			mag = item_q.range - rem1_q;
			sgn = item_q.neg;
		end else begin
			mag = rem1_q;
			sgn = !item_q.neg;
		end
		if (!item_q.ok) begin
			r = '0;
		end else if (rneg_q) begin
			r = -$signed({1'b0, quo_q});
		end else begin
			r = $signed({1'b0, quo_q});
		end
		p_abs = prod_q[64] ? 65'(-prod_q) : 65'(prod_q);
		t_mag = 64'((p_abs + 65'h8000) >> 16);
		term = prod_q[64] ? -$signed(t_mag) : $signed(t_mag);
		g32 = 64'(item_q.grad) <<< 16;
		next_upper = sat_add(sum_upper_q,
			(item_q.region == REG_ABOVE) ? term + g32 : term);
		next_lower = sat_add(sum_lower_q,
			(item_q.region == REG_BELOW) ? g32 - term : -term);
		acc_go = !item_q.last || !res_valid_q || !res_stall;

		state_d = state_q;
		item_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (cnt_q == '0) begin
					state_d = ST_RES;
				end
			end
			ST_RES: state_d = ST_DIV2;
			ST_DIV2: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (acc_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= item;
				den_q <= DEN_W'(item.range) * DEN_W'(STEP);
				num_q <= {item.mag, (NUM_W-A_W)'(0)};
				rem1_q <= '0;
				cnt_q <= CNT_W'(A_W - 1);
			end
			ST_DIV1: begin
				if (trial1 >= {1'b0, item_q.range}) begin
					rem1_q <= 32'(trial1 - {1'b0, item_q.range});
				end else begin
					rem1_q <= trial1[31:0];
				end
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_RES: begin
				num_q <= {mag, 32'd0} + NUM_W'(den_q >> 1);
				rneg_q <= sgn;
				rem2_q <= '0;
				quo_q <= '0;
				cnt_q <= CNT_W'(NUM_W - 1);
			end
			ST_DIV2: begin
				if (trial2 >= {1'b0, den_q}) begin
					rem2_q <= DEN_W'(trial2 - {1'b0, den_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem2_q <= trial2[DEN_W-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL: prod_q <= 65'(item_q.grad) * 65'(r);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_upper_q <= '0;
			sum_lower_q <= '0;
			err_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_ACC && acc_go) begin
				if (item_q.last) begin
					res_q.grad_upper <= next_upper;
					res_q.grad_lower <= next_lower;
					res_q.range_error <= err_q || !item_q.ok;
					res_valid_q <= 1'b1;
					sum_upper_q <= '0;
					sum_lower_q <= '0;
					err_q <= 1'b0;
				end else begin
					sum_upper_q <= next_upper;
					sum_lower_q <= next_lower;
					err_q <= err_q || !item_q.ok;
				end
			end
		end
	end
endmodule

>>> rtl/qcga_checker.sv
module qcga_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           act_stall,
	input logic           res_valid,
	input logic           res_stall,
	input qcga_pkg::res_t res
);
	assert property (@(posedge clk) !arst_n |-> !res_valid && !act_stall)
		else $error("Outputs active during reset.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("Result dropped while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("Result changed while stalled.");
endmodule

bind quant_clip_gradient_accumulator_core qcga_checker u_qcga_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.act_stall (act_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

>>> test/quant_clip_gradient_accumulator_core_tb.sv
`timescale 1ns / 100ps

module quant_clip_gradient_accumulator_core_tb;
	import qcga_pkg::*;

	localparam longint SUM_MAX = 64'sh7fffffffffffffff;
	localparam longint SUM_MIN = -64'sh7fffffffffffffff - 1;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;
	localparam int LONG_HOLD = 400;

	logic        clk;
	logic        arst_n;
	logic        act_valid;
	logic        act_stall;
	act_t        act;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	logic [31:0] cfg_data;

	act_t pending_acts[$];
	res_t expected_sums[$];

	logic signed [31:0] clip_hi, clip_lo, orig_hi, orig_lo;
	longint acc_upper, acc_lower;
	bit     range_bad_seen;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	bit  hold_taken;
	int  hold_left;
	int  errors;
	int  quiet_cycles;

	quant_clip_gradient_accumulator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.act_valid(act_valid),
		.act_stall(act_stall),
		.act(act),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat_add(longint a, longint b);
		if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
		if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
		return a + b;
	endfunction

	function automatic longint rounding_residue(longint v, longint d);
		longint n, a, qa, rm;
		longint unsigned mag, den, q;
		bit neg, rneg;
		n = v * longint'(STEP);
		neg = n < 0;
		a = neg ? -n : n;
		qa = (2 * a + d) / (2 * d);
		rm = qa * d - a;
		if (neg) rm = -rm;
		rneg = rm < 0;
		mag = rneg ? -rm : rm;
		den = d * longint'(STEP);
		q = ((mag << 32) + den / 2) / den;
		return rneg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint grad_times_residue(longint g, longint r);
		longint p;
		longint unsigned m;
		bit neg;
		p = g * r;
		neg = p < 0;
		m = neg ? -p : p;
		m = (m + 64'h8000) >> 16;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic bit accumulate_clip_grads(input act_t a, output res_t sums);
		longint x, g, d, r, term, g32;
		bit ok;
		x = a.activation;
		g = a.upstream_grad;
		d = longint'(orig_hi) - longint'(orig_lo);
		g32 = g * 65536;
		ok = d > 0;
		if (!ok) range_bad_seen = 1'b1;
		if (x > clip_hi) begin
			r = ok ? rounding_residue(orig_lo, d) : 0;
			term = grad_times_residue(g, r);
			acc_upper = sat_add(acc_upper, term + g32);
			acc_lower = sat_add(acc_lower, -term);
		end else if (x < clip_lo) begin
			r = ok ? rounding_residue(orig_lo, d) : 0;
			term = grad_times_residue(g, r);
			acc_upper = sat_add(acc_upper, term);
			acc_lower = sat_add(acc_lower, g32 - term);
		end else begin
			r = ok ? rounding_residue(x, d) : 0;
			term = grad_times_residue(g, r);
			acc_upper = sat_add(acc_upper, term);
			acc_lower = sat_add(acc_lower, -term);
		end
		sums = '0;
		if (!a.last) return 1'b0;
		sums.grad_upper = acc_upper;
		sums.grad_lower = acc_lower;
		sums.range_error = range_bad_seen;
		acc_upper = 0;
		acc_lower = 0;
		range_bad_seen = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid <= 1'b0;
			act <= '0;
		end else if (!act_valid || !act_stall) begin
			if (pending_acts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				act_valid <= 1'b1;
				act <= pending_acts.pop_front();
			end else begin
				act_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken && res_valid && res_stall) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			res_stall <= 1'b1;
		end else begin
			res_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		res_t sums;
		res_t want;
		if (arst_n && act_valid && !act_stall) begin
			if (accumulate_clip_grads(act, sums)) expected_sums.push_back(sums);
		end
		if (arst_n && res_valid && !res_stall) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: unexpected result transfer %h", $time, res);
				errors++;
			end else begin
				want = expected_sums.pop_front();
				if (res.grad_upper !== want.grad_upper) begin
					$display("%0t: grad_upper expected %h actual %h", $time,
						want.grad_upper, res.grad_upper);
					errors++;
				end
				if (res.grad_lower !== want.grad_lower) begin
					$display("%0t: grad_lower expected %h actual %h", $time,
						want.grad_lower, res.grad_lower);
					errors++;
				end
				if (res.range_error !== want.range_error) begin
					$display("%0t: range_error expected %b actual %b", $time,
						want.range_error, res.range_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((act_valid && !act_stall) || (res_valid && !res_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_CLIP_UPPER: clip_hi = value;
			CFG_CLIP_LOWER: clip_lo = value;
			CFG_ORIG_UPPER: orig_hi = value;
			default:        orig_lo = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_bounds(logic [31:0] cu, logic [31:0] cl,
			logic [31:0] ou, logic [31:0] ol);
		write_reg(CFG_CLIP_UPPER, cu);
		write_reg(CFG_CLIP_LOWER, cl);
		write_reg(CFG_ORIG_UPPER, ou);
		write_reg(CFG_ORIG_LOWER, ol);
	endtask

	task automatic push_act(logic [31:0] x, logic [31:0] g, logic lst);
		act_t a;
		a.activation = x;
		a.upstream_grad = g;
		a.last = lst;
		pending_acts.push_back(a);
	endtask

	function automatic logic [31:0] pick_activation();
		longint lo, hi, span, v;
		if ($urandom_range(3) == 0) return $urandom;
		lo = longint'(clip_lo) - 2000;
		hi = longint'(clip_hi) + 2000;
		if (hi < lo) begin
			v = lo;
			lo = hi;
			hi = v;
		end
		span = hi - lo + 1;
		v = lo + longint'({$urandom, $urandom} % longint'(unsigned'(span)));
		if (v > 64'sh7fffffff) v = 64'sh7fffffff;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return v[31:0];
	endfunction

	task automatic push_tensors(int count);
		logic [31:0] g;
		for (int i = 0; i < count; i++) begin
			g = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(262143)) - 131072);
			push_act(pick_activation(), g, (i == count - 1) || ($urandom_range(6) == 0));
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_acts.size() > 0 || act_valid || expected_sums.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CLIP_UPPER;
		cfg_data = '0;
		clip_hi = 32'sd65536;
		clip_lo = -32'sd65536;
		orig_hi = 32'sd65536;
		orig_lo = -32'sd65536;
		acc_upper = 0;
		acc_lower = 0;
		range_bad_seen = 1'b0;
		send_idle_pct = 8;
		recv_stall_pct = 52;
		hold_req = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		push_act(32'h0000_0000, 32'h7fff_ffff, 1'b0);
		push_act(32'h0001_0000, 32'h8000_0000, 1'b0);
		push_act(32'hffff_0000, 32'h0001_0000, 1'b1);
		push_act(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		push_act(32'h8000_0000, 32'hffff_ffff, 1'b1);
		push_act(32'h0000_0101, 32'h7fff_ffff, 1'b0);
		push_act(32'h0001_0001, 32'h7fff_ffff, 1'b0);
		push_act(32'hfffe_ffff, 32'h7fff_ffff, 1'b1);
		push_act(32'h0000_0080, 32'h0000_0000, 1'b1);
		for (int i = 0; i < 40; i++) push_act(32'h7fff_ffff, 32'h7fff_ffff, i == 39);
		wait_drained();

		set_bounds(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		push_act(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		push_act(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		push_act(32'h0000_1234, 32'h0abc_def0, 1'b1);
		push_tensors(100);
		hold_req = 1'b1;
		wait_drained();

		set_bounds(32'h0000_0000, 32'h0000_0000, 32'h0002_0000, 32'h0002_0000);
		push_act(32'h0000_0000, 32'h7fff_ffff, 1'b0);
		push_act(32'h0000_0001, 32'h8000_0000, 1'b0);
		push_act(32'hffff_ffff, 32'h1234_5678, 1'b1);
		push_tensors(60);
		wait_drained();

		send_idle_pct = 52;
		recv_stall_pct = 8;
		set_bounds(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		push_tensors(60);
		wait_drained();

		set_bounds(32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 32'h0000_0000);
		push_tensors(100);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			if (p > 0) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			set_bounds($urandom, $urandom,
				32'($signed($urandom_range(32'h3fff_ffff))),
				32'(-$signed($urandom_range(32'h3fff_ffff))));
			push_tensors(100);
			wait_drained();
		end

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
